>>> rtl/imh_pkg.sv
package imh_pkg;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_PEEK = 3'd1;
  localparam logic [2:0] ACT_DELMIN = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_MODIFY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DEAD = 2'd3;

  // Result of one signed compare made by the shared comparator.
  typedef struct packed {
    logic lt;
  } cmp_res_t;

endpackage

>>> rtl/imh_cmp.sv
module imh_cmp (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output imh_pkg::cmp_res_t  res
);

  // The one comparator that every sift step shares.
  assign res.lt = a < b;

endmodule

>>> rtl/indexed_min_heap.sv
// Indexed binary min-heap of signed 32-bit values.
// Input channel (in_valid, in_stall, in_action, in_value, in_handle) takes one
// word per action: insert, peek, delete min, delete by handle, modify by handle.
// Output channel (out_valid, out_stall, out_status, out_min_value,
// out_new_handle, out_count) returns exactly one word per input word.
// A small sequencer drives one shared signed comparator and the slot, owner
// and handle memories; every memory access has registered read data. One
// level of a downward sift reads and compares the left child, reads and
// compares the right child, decides, and writes back both slots with their
// handle entries; one level of an upward sift reads and compares the parent
// and writes back both slots. The input is stalled while an item is at work.
// A finished word sits in the output register; while out_stall is high the
// word holds and the next input word may still be accepted and worked on, but
// its result waits until the register is free.
// Reset (rst_n low, synchronous) empties the heap, clears the handle counter
// and runs a clearing pass over the handle live bits, one entry a cycle,
// during which no input word is accepted.
module indexed_min_heap #(
  parameter int CAPACITY = 1024,
  parameter int HANDLES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [11:0]        in_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_min_value,
  output logic [11:0]        out_new_handle,
  output logic [10:0]        out_count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int HW = $clog2(HANDLES);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(HANDLES + 1);

  localparam logic [4:0] S_CLR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_LIVE = 5'd2;
  localparam logic [4:0] S_LIVE2 = 5'd3;
  localparam logic [4:0] S_OSLOT = 5'd4;
  localparam logic [4:0] S_RD_A = 5'd5;
  localparam logic [4:0] S_RD_A2 = 5'd6;
  localparam logic [4:0] S_RD_B = 5'd7;
  localparam logic [4:0] S_RD_B2 = 5'd8;
  localparam logic [4:0] S_WR_A = 5'd9;
  localparam logic [4:0] S_WR_B = 5'd10;
  localparam logic [4:0] S_DN_L = 5'd11;
  localparam logic [4:0] S_DN_L2 = 5'd12;
  localparam logic [4:0] S_DN_R = 5'd13;
  localparam logic [4:0] S_DN_R2 = 5'd14;
  localparam logic [4:0] S_DN_DEC = 5'd15;
  localparam logic [4:0] S_UP_P = 5'd16;
  localparam logic [4:0] S_UP_P2 = 5'd17;
  localparam logic [4:0] S_UP_DEC = 5'd18;
  localparam logic [4:0] S_ROOT = 5'd19;
  localparam logic [4:0] S_ROOT2 = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;
  localparam logic [4:0] S_INS = 5'd22;
  localparam logic [4:0] S_MODW = 5'd23;

  logic [4:0] state_r, state_nxt;

  // Slot memory: value and owner per slot, one port.
  logic signed [31:0] slot_value [CAPACITY];
  logic [HW-1:0]      slot_owner [CAPACITY];
  logic [SW-1:0]      owner_slot [HANDLES];
  logic               owner_live [HANDLES];

  logic               sm_we;
  logic [SW-1:0]      sm_addr;
  logic signed [31:0] sm_wval;
  logic [HW-1:0]      sm_wown;
  logic signed [31:0] sm_rval;
  logic [HW-1:0]      sm_rown;

  logic               om_we;
  logic [HW-1:0]      om_addr;
  logic [SW-1:0]      om_wslot;
  logic [SW-1:0]      om_rslot;

  logic               lm_we;
  logic [HW-1:0]      lm_addr;
  logic               lm_wbit;
  logic               lm_rbit;

  always_ff @(posedge clk) begin
    if (sm_we) begin
      slot_value[sm_addr] <= sm_wval;
      slot_owner[sm_addr] <= sm_wown;
    end
    sm_rval <= slot_value[sm_addr];
    sm_rown <= slot_owner[sm_addr];
  end

  always_ff @(posedge clk) begin
    if (om_we) begin
      owner_slot[om_addr] <= om_wslot;
    end
    om_rslot <= owner_slot[om_addr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      owner_live[lm_addr] <= lm_wbit;
    end
    lm_rbit <= owner_live[lm_addr];
  end

  logic [CW-1:0]      count_r, count_nxt;
  logic [NW-1:0]      nexth_r, nexth_nxt;
  logic [HW-1:0]      clr_r, clr_nxt;
  logic [2:0]         act_r, act_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [11:0]        hdl_r, hdl_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [11:0]        given_r, given_nxt;
  // Current slot i and its entry, and the best candidate found so far.
  logic [SW-1:0]      cur_r, cur_nxt;
  logic signed [31:0] cval_r, cval_nxt;
  logic [HW-1:0]      cown_r, cown_nxt;
  logic [SW-1:0]      bst_r, bst_nxt;
  logic signed [31:0] bval_r, bval_nxt;
  logic [HW-1:0]      bown_r, bown_nxt;
  // Swap partner slots a and b (and their entries) for the write sequence.
  logic [SW-1:0]      pa_r, pa_nxt;
  logic [SW-1:0]      pb_r, pb_nxt;
  logic signed [31:0] av_r, av_nxt;
  logic [HW-1:0]      ao_r, ao_nxt;
  logic signed [31:0] bv_r, bv_nxt;
  logic [HW-1:0]      bo_r, bo_nxt;
  logic [4:0]         ret_r, ret_nxt;
  logic signed [31:0] minv_r, minv_nxt;

  logic               ov_r, ov_nxt;
  logic [1:0]         os_r, os_nxt;
  logic signed [31:0] om_r, om_nxt;
  logic [11:0]        oh_r, oh_nxt;
  logic [10:0]        oc_r, oc_nxt;

  logic signed [31:0] cmp_a, cmp_b;
  imh_pkg::cmp_res_t  cmp_res;

  imh_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Child and parent indexes, kept one bit wider to detect running off the end.
  logic [SW:0] left_w, right_w, par_w;
  assign left_w = {cur_r, 1'b1};
  assign right_w = {cur_r, 1'b0} + {{SW{1'b0}}, 1'b1} + {{SW{1'b0}}, 1'b1};
  assign par_w = ({1'b0, cur_r} - {{SW{1'b0}}, 1'b1}) >> 1;

  logic hdl_in_range;
  assign hdl_in_range = (HANDLES >= 4096) || ({20'd0, hdl_r} < HANDLES);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    nexth_nxt = nexth_r;
    clr_nxt = clr_r;
    act_nxt = act_r;
    val_nxt = val_r;
    hdl_nxt = hdl_r;
    stat_nxt = stat_r;
    given_nxt = given_r;
    cur_nxt = cur_r;
    cval_nxt = cval_r;
    cown_nxt = cown_r;
    bst_nxt = bst_r;
    bval_nxt = bval_r;
    bown_nxt = bown_r;
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    av_nxt = av_r;
    ao_nxt = ao_r;
    bv_nxt = bv_r;
    bo_nxt = bo_r;
    ret_nxt = ret_r;
    minv_nxt = minv_r;
    ov_nxt = ov_r;
    os_nxt = os_r;
    om_nxt = om_r;
    oh_nxt = oh_r;
    oc_nxt = oc_r;
    sm_we = 1'b0;
    sm_addr = cur_r;
    sm_wval = cval_r;
    sm_wown = cown_r;
    om_we = 1'b0;
    om_addr = cown_r;
    om_wslot = cur_r;
    lm_we = 1'b0;
    lm_addr = hdl_r[HW-1:0];
    lm_wbit = 1'b0;
    cmp_a = cval_r;
    cmp_b = bval_r;
    in_stall = 1'b1;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        lm_we = 1'b1;
        lm_addr = clr_r;
        lm_wbit = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if ({{(32-HW){1'b0}}, clr_r} == HANDLES - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          act_nxt = in_action;
          val_nxt = in_value;
          hdl_nxt = in_handle;
          stat_nxt = imh_pkg::ST_OK;
          given_nxt = 12'd0;
          case (in_action)
            imh_pkg::ACT_INSERT: begin
              if ({{(32-CW){1'b0}}, count_r} >= CAPACITY
                  || {{(32-NW){1'b0}}, nexth_r} >= HANDLES) begin
                stat_nxt = imh_pkg::ST_FULL;
                state_nxt = S_ROOT;
              end else begin
                state_nxt = S_INS;
              end
            end
            imh_pkg::ACT_DELMIN: begin
              if (count_r == '0) begin
                stat_nxt = imh_pkg::ST_EMPTY;
                state_nxt = S_ROOT;
              end else begin
                cur_nxt = '0;
                state_nxt = S_RD_A;
              end
            end
            imh_pkg::ACT_DELETE, imh_pkg::ACT_MODIFY: begin
              state_nxt = S_LIVE;
            end
            default: begin
              if (count_r == '0) begin
                stat_nxt = imh_pkg::ST_EMPTY;
              end
              state_nxt = S_ROOT;
            end
          endcase
        end
      end
      S_INS: begin
        // Place the new entry in the last slot, then sift it up.
        cur_nxt = count_r[SW-1:0];
        cval_nxt = val_r;
        cown_nxt = nexth_r[HW-1:0];
        sm_we = 1'b1;
        sm_addr = count_r[SW-1:0];
        sm_wval = val_r;
        sm_wown = nexth_r[HW-1:0];
        om_we = 1'b1;
        om_addr = nexth_r[HW-1:0];
        om_wslot = count_r[SW-1:0];
        lm_we = 1'b1;
        lm_addr = nexth_r[HW-1:0];
        lm_wbit = 1'b1;
        given_nxt = 12'(nexth_r);
        nexth_nxt = nexth_r + 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_UP_P;
      end
      S_LIVE: begin
        lm_addr = hdl_r[HW-1:0];
        om_addr = hdl_r[HW-1:0];
        state_nxt = S_LIVE2;
      end
      S_LIVE2: begin
        if (!(hdl_in_range && lm_rbit)) begin
          stat_nxt = imh_pkg::ST_DEAD;
          state_nxt = S_ROOT;
        end else begin
          cur_nxt = om_rslot;
          if (act_r == imh_pkg::ACT_DELETE) begin
            state_nxt = S_RD_A;
          end else begin
            state_nxt = S_OSLOT;
          end
        end
      end
      S_OSLOT: begin
        sm_addr = cur_r;
        state_nxt = S_MODW;
      end
      S_MODW: begin
        // Rewrite the value of the modified slot and start the sift.
        cval_nxt = val_r;
        cown_nxt = sm_rown;
        sm_we = 1'b1;
        sm_addr = cur_r;
        sm_wval = val_r;
        sm_wown = sm_rown;
        bst_nxt = cur_r;
        bval_nxt = val_r;
        bown_nxt = sm_rown;
        state_nxt = S_DN_L;
      end
      S_RD_A: begin
        sm_addr = cur_r;
        state_nxt = S_RD_A2;
      end
      S_RD_A2: begin
        // Removed entry: clear its live bit, then fetch the last slot.
        lm_we = 1'b1;
        lm_addr = sm_rown;
        lm_wbit = 1'b0;
        pb_nxt = SW'(count_r - 1'b1);
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        sm_addr = pb_r;
        state_nxt = S_RD_B2;
      end
      S_RD_B2: begin
        count_nxt = count_r - 1'b1;
        if (pb_r == cur_r) begin
          state_nxt = S_ROOT;
        end else begin
          cval_nxt = sm_rval;
          cown_nxt = sm_rown;
          sm_we = 1'b1;
          sm_addr = cur_r;
          sm_wval = sm_rval;
          sm_wown = sm_rown;
          om_we = 1'b1;
          om_addr = sm_rown;
          om_wslot = cur_r;
          bst_nxt = cur_r;
          bval_nxt = sm_rval;
          bown_nxt = sm_rown;
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        if ({{(31-SW){1'b0}}, left_w} < {{(32-CW){1'b0}}, count_r}) begin
          sm_addr = left_w[SW-1:0];
          state_nxt = S_DN_L2;
        end else begin
          state_nxt = S_DN_DEC;
        end
      end
      S_DN_L2: begin
        cmp_a = sm_rval;
        cmp_b = bval_r;
        if (cmp_res.lt) begin
          bst_nxt = left_w[SW-1:0];
          bval_nxt = sm_rval;
          bown_nxt = sm_rown;
        end
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        if ({{(31-SW){1'b0}}, right_w} < {{(32-CW){1'b0}}, count_r}) begin
          sm_addr = right_w[SW-1:0];
          state_nxt = S_DN_R2;
        end else begin
          state_nxt = S_DN_DEC;
        end
      end
      S_DN_R2: begin
        cmp_a = sm_rval;
        cmp_b = bval_r;
        if (cmp_res.lt) begin
          bst_nxt = right_w[SW-1:0];
          bval_nxt = sm_rval;
          bown_nxt = sm_rown;
        end
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (bst_r == cur_r) begin
          state_nxt = S_UP_P;
        end else begin
          pa_nxt = cur_r;
          pb_nxt = bst_r;
          av_nxt = bval_r;
          ao_nxt = bown_r;
          bv_nxt = cval_r;
          bo_nxt = cown_r;
          ret_nxt = S_DN_L;
          cur_nxt = bst_r;
          state_nxt = S_WR_A;
        end
      end
      S_UP_P: begin
        if (cur_r == '0) begin
          state_nxt = S_ROOT;
        end else begin
          sm_addr = par_w[SW-1:0];
          state_nxt = S_UP_P2;
        end
      end
      S_UP_P2: begin
        cmp_a = cval_r;
        cmp_b = sm_rval;
        if (cmp_res.lt) begin
          pa_nxt = par_w[SW-1:0];
          pb_nxt = cur_r;
          av_nxt = cval_r;
          ao_nxt = cown_r;
          bv_nxt = sm_rval;
          bo_nxt = sm_rown;
          ret_nxt = S_UP_P;
          cur_nxt = par_w[SW-1:0];
          state_nxt = S_WR_A;
        end else begin
          state_nxt = S_ROOT;
        end
      end
      S_WR_A: begin
        sm_we = 1'b1;
        sm_addr = pa_r;
        sm_wval = av_r;
        sm_wown = ao_r;
        om_we = 1'b1;
        om_addr = ao_r;
        om_wslot = pa_r;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        sm_we = 1'b1;
        sm_addr = pb_r;
        sm_wval = bv_r;
        sm_wown = bo_r;
        om_we = 1'b1;
        om_addr = bo_r;
        om_wslot = pb_r;
        // The moving entry keeps its value at the new current slot.
        if (ret_r == S_DN_L) begin
          cval_nxt = bv_r;
          cown_nxt = bo_r;
          bval_nxt = bv_r;
          bown_nxt = bo_r;
          bst_nxt = pb_r;
        end
        state_nxt = ret_r;
      end
      S_ROOT: begin
        sm_addr = '0;
        state_nxt = S_ROOT2;
      end
      S_ROOT2: begin
        minv_nxt = (count_r == '0) ? 32'sd0 : sm_rval;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          os_nxt = stat_r;
          om_nxt = minv_r;
          oh_nxt = given_r;
          oc_nxt = 11'(count_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      count_r <= '0;
      nexth_r <= '0;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      nexth_r <= nexth_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    val_r <= val_nxt;
    hdl_r <= hdl_nxt;
    stat_r <= stat_nxt;
    given_r <= given_nxt;
    cur_r <= cur_nxt;
    cval_r <= cval_nxt;
    cown_r <= cown_nxt;
    bst_r <= bst_nxt;
    bval_r <= bval_nxt;
    bown_r <= bown_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    av_r <= av_nxt;
    ao_r <= ao_nxt;
    bv_r <= bv_nxt;
    bo_r <= bo_nxt;
    ret_r <= ret_nxt;
    minv_r <= minv_nxt;
    os_r <= os_nxt;
    om_r <= om_nxt;
    oh_r <= oh_nxt;
    oc_r <= oc_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_min_value = om_r;
  assign out_new_handle = oh_r;
  assign out_count = oc_r;

  // The heap never holds more entries than it has slots.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CW){1'b0}}, count_r} <= CAPACITY)
    else $error("heap count above capacity");

  // Input is taken only in the idle state.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE)
    else $error("input taken while busy");

  // An insert that succeeds raises the handle counter by one.
  a_ins_handle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |=> nexth_r == $past(nexth_r) + 1'b1)
    else $error("handle counter not advanced");

  // The count changes only by one and only inside an item; this checks that it holds while idle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(count_r))
    else $error("count changed while idle");

endmodule
